[hdl/stationary_bias_calibrated_accel_assert.svh]
// Assertion macros for the stationary bias calibrated accelerometer.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef STATIONARY_BIAS_CALIBRATED_ACCEL_ASSERT_SVH
`define STATIONARY_BIAS_CALIBRATED_ACCEL_ASSERT_SVH
`ifndef SYNTHESIS
`define SBCA_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbca assertion failed");
`define SBCA_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbca assertion failed");
`else
`define SBCA_AST_IMP(lbl, ante, cons)
`define SBCA_AST_NXT(lbl, ante, cons)
`endif
`endif

[hdl/sbca_pkg.sv]
// Package for the stationary bias calibrated accelerometer.
// Transaction types, register codes, sequencer states and fixed constants.
package sbca_pkg;

    typedef struct packed {
        logic               sensor_ok;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } t_in_item;

    typedef struct packed {
        logic               online;
        logic               is_still;
        logic               bias_ready;
        logic signed [15:0] bias_value;
        logic signed [18:0] forward_accel;
    } t_out_item;

    typedef enum logic [2:0] {
        CFG_GYRO_LIMIT = 3'd0,
        CFG_NORM_MIN   = 3'd1,
        CFG_NORM_MAX   = 3'd2,
        CFG_TARGET     = 3'd3,
        CFG_GAIN       = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SQZ,
        S_NSQ,
        S_CHK,
        S_DIV,
        S_DIVW,
        S_SCALE,
        S_DIFF,
        S_GAIN,
        S_FILT,
        S_OUT
    } t_state;

    localparam int MulAW = 35;
    localparam int MulBW = 18;
    localparam int ProdW = MulAW + MulBW;
    localparam int DivNW = 27;
    localparam int DivDW = 10;

    typedef struct packed {
        logic                    en;
        logic signed [MulAW-1:0] a;
        logic signed [MulBW-1:0] b;
    } t_mul_req;

    // 9.80665 / 4 in Q15
    localparam logic signed [MulBW-1:0] G_SCALE_Q15 = 18'sd80336;

    localparam logic [14:0] RST_GYRO_LIMIT = 15'd48;
    localparam logic [31:0] RST_NORM_MIN   = 32'd15099494;
    localparam logic [31:0] RST_NORM_MAX   = 32'd18454938;
    localparam logic [9:0]  RST_TARGET     = 10'd200;
    localparam logic [15:0] RST_GAIN       = 16'd13107;

endpackage

[hdl/sbca_mul.sv]
// Shared registered signed multiplier.
// Uses sbca_pkg for the request type and operand widths.
module sbca_mul (
    input  logic                                i_clk,
    input  sbca_pkg::t_mul_req                  i_req,
    output logic signed [sbca_pkg::ProdW-1:0]   o_prod
);

    logic signed [sbca_pkg::ProdW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= i_req.a * i_req.b;
        end
    end

    assign o_prod = r_prod;

endmodule

[hdl/sbca_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses sbca_pkg for widths; assertions from the assert header.
`include "stationary_bias_calibrated_accel_assert.svh"
module sbca_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sbca_pkg::DivNW-1:0]    i_dividend,
    input  logic [sbca_pkg::DivDW-1:0]    i_divisor,
    output logic                          o_done,
    output logic [sbca_pkg::DivNW-1:0]    o_quot
);

    localparam int CntW = $clog2(sbca_pkg::DivNW);

    logic                         r_busy;
    logic                         r_done;
    logic [CntW-1:0]              r_cnt;
    logic [sbca_pkg::DivDW-1:0]   r_rem;
    logic [sbca_pkg::DivDW-1:0]   r_dvs;
    logic [sbca_pkg::DivNW-1:0]   r_quo;
    logic [sbca_pkg::DivDW:0]     w_shift;
    logic [sbca_pkg::DivDW+1:0]   w_trial;
    logic                         w_ge;

    assign w_shift = {r_rem, r_quo[sbca_pkg::DivNW-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_dvs};
    assign w_ge    = !w_trial[sbca_pkg::DivDW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(sbca_pkg::DivNW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_trial[sbca_pkg::DivDW-1:0] : w_shift[sbca_pkg::DivDW-1:0];
            r_quo <= {r_quo[sbca_pkg::DivNW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    `SBCA_AST_IMP(a_div_start_idle, i_start, !r_busy)

endmodule

[hdl/stationary_bias_calibrated_accel.sv]
// An offline sample goes straight to the output register; a still or moving sample before
// calibration is squared and checked for stillness; a calibrated sample also runs the
// filter on the shared multiplier; the sample completing calibration first waits on the
// 27-step serial divider. One transaction in flight; the next is accepted once the
// result sits in the output register. Reset (synchronous, active low) restores register
// defaults and clears the calibration and filter state; no clearing pass follows.
`include "stationary_bias_calibrated_accel_assert.svh"
module stationary_bias_calibrated_accel (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sbca_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sbca_pkg::t_out_item   o_out_data,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_data
);

    sbca_pkg::t_state    r_state;
    sbca_pkg::t_state    n_state;
    sbca_pkg::t_in_item  r_in;
    sbca_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic [14:0] r_gyro_limit;
    logic [31:0] r_norm_min;
    logic [31:0] r_norm_max;
    logic [9:0]  r_target;
    logic [15:0] r_gain;

    logic               r_online;
    logic               r_ready;
    logic               r_still;
    logic signed [26:0] r_sum;
    logic [9:0]         r_cnt;
    logic signed [15:0] r_bias;
    logic signed [33:0] r_fv;
    logic [31:0]        r_nsq;
    logic signed [34:0] r_diff;

    sbca_pkg::t_mul_req                  w_mreq;
    logic signed [sbca_pkg::ProdW-1:0]   w_prod;
    logic                                w_div_start;
    logic                                w_div_done;
    logic [sbca_pkg::DivNW-1:0]          w_quot;
    logic [sbca_pkg::DivNW-1:0]          w_abs_sum;
    logic [sbca_pkg::DivNW-1:0]          w_dividend;
    logic [sbca_pkg::DivDW-1:0]          w_divisor;

    logic               w_in_acc;
    logic               w_load;
    logic [15:0]        w_abs_gx;
    logic [15:0]        w_abs_gy;
    logic [15:0]        w_abs_gz;
    logic               w_still;
    logic [9:0]         w_cnt_next;
    logic signed [16:0] w_ay17;
    logic signed [16:0] w_neg_ay;
    logic signed [17:0] w_err;
    logic signed [15:0] w_bias_sat;
    logic signed [34:0] w_round;
    logic signed [18:0] w_fwd;

    assign w_in_acc = i_in_valid && o_in_ready;

    assign w_abs_gx = r_in.gyro_x[15] ? 16'(-r_in.gyro_x) : r_in.gyro_x;
    assign w_abs_gy = r_in.gyro_y[15] ? 16'(-r_in.gyro_y) : r_in.gyro_y;
    assign w_abs_gz = r_in.gyro_z[15] ? 16'(-r_in.gyro_z) : r_in.gyro_z;
    assign w_still  = (r_nsq >= r_norm_min) && (r_nsq <= r_norm_max)
                   && (w_abs_gx <= {1'b0, r_gyro_limit})
                   && (w_abs_gy <= {1'b0, r_gyro_limit})
                   && (w_abs_gz <= {1'b0, r_gyro_limit});
    assign w_cnt_next = r_cnt + 10'd1;

    assign w_ay17   = {r_in.accel_y[15], r_in.accel_y};
    assign w_neg_ay = -w_ay17;
    assign w_err    = {w_neg_ay[16], w_neg_ay} - {{2{r_bias[15]}}, r_bias};

    assign w_abs_sum  = r_sum[26] ? 27'(-r_sum) : r_sum;
    assign w_dividend = w_abs_sum + {18'd0, r_cnt[9:1]};
    assign w_divisor  = (r_cnt == 10'd0) ? 10'd1 : r_cnt;

    always_comb begin
        if (r_sum[26]) begin
            w_bias_sat = (w_quot > 27'd32768) ? -16'sd32768 : 16'(-w_quot);
        end else begin
            w_bias_sat = (|w_quot[26:15]) ? 16'sd32767 : w_quot[15:0];
        end
    end

    assign w_round = {r_fv[33], r_fv} + 35'sd16384;
    always_comb begin
        if (!r_ready) begin
            w_fwd = '0;
        end else if (w_round[34] != w_round[33]) begin
            w_fwd = w_round[34] ? -19'sd262144 : 19'sd262143;
        end else begin
            w_fwd = w_round[33:15];
        end
    end

    sbca_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mreq),
        .o_prod (w_prod)
    );

    sbca_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbca_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (r_online && i_in_data.sensor_ok) ? sbca_pkg::S_SQX
                                                                : sbca_pkg::S_OUT;
                end
            end
            sbca_pkg::S_SQX:   n_state = sbca_pkg::S_SQY;
            sbca_pkg::S_SQY:   n_state = sbca_pkg::S_SQZ;
            sbca_pkg::S_SQZ:   n_state = sbca_pkg::S_NSQ;
            sbca_pkg::S_NSQ:   n_state = sbca_pkg::S_CHK;
            sbca_pkg::S_CHK: begin
                if (r_ready) begin
                    n_state = sbca_pkg::S_SCALE;
                end else if (w_still && (w_cnt_next >= r_target)) begin
                    n_state = sbca_pkg::S_DIV;
                end else begin
                    n_state = sbca_pkg::S_OUT;
                end
            end
            sbca_pkg::S_DIV:   n_state = sbca_pkg::S_DIVW;
            sbca_pkg::S_DIVW: begin
                if (w_div_done) begin
                    n_state = sbca_pkg::S_SCALE;
                end
            end
            sbca_pkg::S_SCALE: n_state = sbca_pkg::S_DIFF;
            sbca_pkg::S_DIFF:  n_state = sbca_pkg::S_GAIN;
            sbca_pkg::S_GAIN:  n_state = sbca_pkg::S_FILT;
            sbca_pkg::S_FILT:  n_state = sbca_pkg::S_OUT;
            sbca_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = sbca_pkg::S_IDLE;
                end
            end
            default:           n_state = sbca_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready  = 1'b0;
        w_load      = 1'b0;
        w_div_start = 1'b0;
        w_mreq      = '0;
        case (r_state)
            sbca_pkg::S_IDLE: o_in_ready = 1'b1;
            sbca_pkg::S_SQX: begin
                w_mreq.en = 1'b1;
                w_mreq.a  = {{19{r_in.accel_x[15]}}, r_in.accel_x};
                w_mreq.b  = {{2{r_in.accel_x[15]}}, r_in.accel_x};
            end
            sbca_pkg::S_SQY: begin
                w_mreq.en = 1'b1;
                w_mreq.a  = {{19{r_in.accel_y[15]}}, r_in.accel_y};
                w_mreq.b  = {{2{r_in.accel_y[15]}}, r_in.accel_y};
            end
            sbca_pkg::S_SQZ: begin
                w_mreq.en = 1'b1;
                w_mreq.a  = {{19{r_in.accel_z[15]}}, r_in.accel_z};
                w_mreq.b  = {{2{r_in.accel_z[15]}}, r_in.accel_z};
            end
            sbca_pkg::S_DIV:  w_div_start = 1'b1;
            sbca_pkg::S_SCALE: begin
                w_mreq.en = 1'b1;
                w_mreq.a  = {{17{w_err[17]}}, w_err};
                w_mreq.b  = sbca_pkg::G_SCALE_Q15;
            end
            sbca_pkg::S_GAIN: begin
                w_mreq.en = 1'b1;
                w_mreq.a  = r_diff;
                w_mreq.b  = {2'b00, r_gain};
            end
            sbca_pkg::S_OUT:  w_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sbca_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_gyro_limit <= sbca_pkg::RST_GYRO_LIMIT;
            r_norm_min   <= sbca_pkg::RST_NORM_MIN;
            r_norm_max   <= sbca_pkg::RST_NORM_MAX;
            r_target     <= sbca_pkg::RST_TARGET;
            r_gain       <= sbca_pkg::RST_GAIN;
            r_online     <= 1'b1;
            r_ready      <= 1'b0;
            r_still      <= 1'b0;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_bias       <= '0;
            r_fv         <= '0;
        end else begin
            r_state <= n_state;

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sbca_pkg::CFG_GYRO_LIMIT: r_gyro_limit <= i_cfg_data[14:0];
                    sbca_pkg::CFG_NORM_MIN:   r_norm_min   <= i_cfg_data;
                    sbca_pkg::CFG_NORM_MAX:   r_norm_max   <= i_cfg_data;
                    sbca_pkg::CFG_TARGET:     r_target     <= i_cfg_data[9:0];
                    sbca_pkg::CFG_GAIN:       r_gain       <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (w_in_acc) begin
                r_online <= r_online && i_in_data.sensor_ok;
                r_still  <= 1'b0;
            end

            if (r_state == sbca_pkg::S_CHK) begin
                r_still <= w_still;
                if (!r_ready) begin
                    if (w_still) begin
                        r_sum <= r_sum + {{10{w_neg_ay[16]}}, w_neg_ay};
                        r_cnt <= w_cnt_next;
                    end else begin
                        r_sum <= '0;
                        r_cnt <= '0;
                    end
                end
            end

            if ((r_state == sbca_pkg::S_DIVW) && w_div_done) begin
                r_bias  <= w_bias_sat;
                r_ready <= 1'b1;
            end

            if (r_state == sbca_pkg::S_FILT) begin
                r_fv <= r_fv + w_prod[49:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_data;
        end
        case (r_state)
            sbca_pkg::S_SQY:  r_nsq  <= w_prod[31:0];
            sbca_pkg::S_SQZ:  r_nsq  <= r_nsq + w_prod[31:0];
            sbca_pkg::S_NSQ:  r_nsq  <= r_nsq + w_prod[31:0];
            sbca_pkg::S_DIFF: r_diff <= {w_prod[33], w_prod[33:0]} - {r_fv[33], r_fv};
            default: ;
        endcase
        if (w_load) begin
            r_out.online        <= r_online;
            r_out.is_still      <= r_still;
            r_out.bias_ready    <= r_ready;
            r_out.bias_value    <= r_bias;
            r_out.forward_accel <= w_fwd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SBCA_AST_NXT(a_offline_latched, !r_online, !r_online)
    `SBCA_AST_NXT(a_failed_read_drops, w_in_acc && !i_in_data.sensor_ok, !r_online)
    `SBCA_AST_IMP(a_ready_enters_filter, $rose(r_ready), r_state == sbca_pkg::S_SCALE)
    `SBCA_AST_IMP(a_still_needs_online, (r_state == sbca_pkg::S_OUT) && r_still, r_online)

endmodule
